// ===== hdl/dde_pkg.sv =====
package dde_pkg;

  localparam int unsigned DELTA_SPAN  = 4096;
  localparam int unsigned FRAME_CODES = 512;
  localparam int unsigned MAX_CODES   = 254;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned ADDR_W  = $clog2(DELTA_SPAN);
  localparam int unsigned FRAME_W = $clog2(FRAME_CODES);

  // line tag kept with every table entry, zero marks a swept entry
  localparam int unsigned EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DECR = 2'd1,
    STAT_BIG  = 2'd2,
    STAT_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [CODE_W-1:0]  code;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// ===== hdl/dde_ram.sv =====
module dde_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/delta_dictionary_encoder_unit.sv =====
// Delta dictionary encoder.
// Input channel (in_valid_i / in_ready_o) takes one timestamp request per
// cycle while in_ready_o is high, with a line_start flag. A line start only
// records the time and opens a fresh dictionary; a time equal to the previous
// one gives no result. Every other request gives one result on the output
// channel (out_valid_o / out_ready_i): the byte code of its delta, a
// new-entry flag, the delta itself, frame marking and a status.
// Throughput is one request per cycle while no output stall or table sweep
// holds in_ready_o low. A request's table read starts at the edge that
// accepts it; its decision goes into the output register when that register
// is free. The delta-to-code table sits in one RAM with a registered read; a
// write by the request ahead is forwarded to the one behind it.
// Table entries carry a line tag, so a line start costs nothing except at
// every 255th line start, when the tag wraps and the table is swept, one
// entry a cycle, with in_ready_o low.
// After reset the same sweep runs, then the block acts as if a line began
// at time 0.
// When the receiver stalls the result stays in the output register; the
// request behind it waits in the read stage and in_ready_o stays low while
// both are full.
module delta_dictionary_encoder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dde_pkg::TIME_W-1:0]  time_value_i,
  input  logic                        line_start_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dde_pkg::CODE_W-1:0]  code_o,
  output logic                        new_entry_o,
  output logic [dde_pkg::TIME_W-1:0]  delta_value_o,
  output logic                        frame_start_o,
  output logic [dde_pkg::TIME_W-1:0]  frame_time_o,
  output logic [1:0]                  status_o
);

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_e;

  state_e                        state_q;
  logic [dde_pkg::ADDR_W-1:0]    clr_cnt_q;
  logic [dde_pkg::EPOCH_W-1:0]   epoch_q;
  logic [dde_pkg::TIME_W-1:0]    prev_q;
  logic [dde_pkg::CODE_W-1:0]    codes_q;
  logic [dde_pkg::FRAME_W-1:0]   frame_q;

  // read stage
  logic                          s1_valid_q;
  logic                          s1_start_q;
  logic [dde_pkg::TIME_W-1:0]    s1_time_q;
  logic                          s1_fwd_q;
  dde_pkg::entry_t               s1_fwd_data_q;

  // output register
  logic                          out_valid_q;
  logic [dde_pkg::CODE_W-1:0]    code_q;
  logic                          new_entry_q;
  logic [dde_pkg::TIME_W-1:0]    delta_q;
  logic                          frame_start_q;
  logic [dde_pkg::TIME_W-1:0]    frame_time_q;
  dde_pkg::status_e              status_q;

  logic                          in_fire;
  logic                          out_free;
  logic                          s1_fire;
  logic [dde_pkg::TIME_W-1:0]    s1_delta;
  logic                          s1_eq;
  logic                          s1_lt;
  logic                          s1_big;
  logic                          s1_hit;
  logic                          s1_full;
  logic                          s1_ok;
  logic                          s1_emit;
  logic                          s1_wr;
  logic                          wrap_pending;
  logic [dde_pkg::ADDR_W-1:0]    s1_addr;
  logic [dde_pkg::ADDR_W-1:0]    in_addr;
  logic [dde_pkg::TIME_W-1:0]    prev_next;
  logic [dde_pkg::CODE_W-1:0]    code_next;
  dde_pkg::entry_t               entry;
  dde_pkg::entry_t               wr_entry;
  dde_pkg::status_e              s1_status;
  logic [dde_pkg::ENTRY_W-1:0]   ram_rdata;
  logic                          ram_we;
  logic [dde_pkg::ADDR_W-1:0]    ram_waddr;
  logic [dde_pkg::ENTRY_W-1:0]   ram_wdata;

  // decision for the request in the read stage
  always_comb begin
    s1_delta  = s1_time_q - prev_q;
    s1_eq     = (s1_time_q == prev_q);
    s1_lt     = (s1_time_q < prev_q);
    s1_big    = (s1_delta >= dde_pkg::TIME_W'(dde_pkg::DELTA_SPAN));
    s1_addr   = s1_delta[dde_pkg::ADDR_W-1:0];
    entry     = s1_fwd_q ? s1_fwd_data_q : dde_pkg::entry_t'(ram_rdata);
    s1_hit    = (entry.epoch == epoch_q);
    s1_full   = !s1_hit && (codes_q >= dde_pkg::CODE_W'(dde_pkg::MAX_CODES));
    s1_ok     = !s1_eq && !s1_lt && !s1_big && !s1_full;
    s1_emit   = s1_valid_q && !s1_start_q && !s1_eq;
    code_next = codes_q + dde_pkg::CODE_W'(1);
    if (s1_lt) begin
      s1_status = dde_pkg::STAT_DECR;
    end else if (s1_big) begin
      s1_status = dde_pkg::STAT_BIG;
    end else if (s1_full) begin
      s1_status = dde_pkg::STAT_FULL;
    end else begin
      s1_status = dde_pkg::STAT_OK;
    end
    wr_entry.epoch = epoch_q;
    wr_entry.code  = code_next;
  end

  assign out_free     = !out_valid_q || out_ready_i;
  assign s1_fire      = s1_valid_q && (s1_start_q || s1_eq || out_free);
  assign s1_wr        = s1_fire && !s1_start_q && s1_ok && !s1_hit;
  assign wrap_pending = s1_valid_q && s1_start_q && (epoch_q == dde_pkg::EPOCH_LAST);
  assign in_ready_o   = (state_q == ST_RUN) && (!s1_valid_q || (s1_fire && !wrap_pending));
  assign in_fire      = in_valid_i && in_ready_o;

  // previous time as it stands after the request ahead leaves
  assign prev_next = (s1_fire && (s1_start_q || s1_ok)) ? s1_time_q : prev_q;
  assign in_addr   = time_value_i[dde_pkg::ADDR_W-1:0] - prev_next[dde_pkg::ADDR_W-1:0];

  assign ram_we    = (state_q == ST_CLEAR) || s1_wr;
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : s1_addr;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : wr_entry;

  dde_ram #(
    .WIDTH (dde_pkg::ENTRY_W),
    .DEPTH (dde_pkg::DELTA_SPAN)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      epoch_q     <= dde_pkg::EPOCH_FIRST;
      prev_q      <= '0;
      codes_q     <= '0;
      frame_q     <= '0;
      s1_valid_q  <= 1'b0;
      s1_fwd_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + dde_pkg::ADDR_W'(1);
        if (clr_cnt_q == dde_pkg::ADDR_W'(dde_pkg::DELTA_SPAN - 1)) begin
          state_q <= ST_RUN;
        end
      end

      if (s1_fire) begin
        if (s1_start_q) begin
          prev_q  <= s1_time_q;
          codes_q <= '0;
          frame_q <= '0;
          if (epoch_q == dde_pkg::EPOCH_LAST) begin
            epoch_q   <= dde_pkg::EPOCH_FIRST;
            state_q   <= ST_CLEAR;
            clr_cnt_q <= '0;
          end else begin
            epoch_q <= epoch_q + dde_pkg::EPOCH_W'(1);
          end
        end else if (s1_ok) begin
          prev_q <= s1_time_q;
          if (!s1_hit) begin
            codes_q <= code_next;
          end
          if (frame_q == dde_pkg::FRAME_W'(dde_pkg::FRAME_CODES - 1)) begin
            frame_q <= '0;
          end else begin
            frame_q <= frame_q + dde_pkg::FRAME_W'(1);
          end
        end
      end

      if (in_fire) begin
        s1_valid_q <= 1'b1;
        // catch the write of the request ahead, the ram read misses it
        s1_fwd_q   <= s1_wr && (s1_addr == in_addr);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
        s1_fwd_q   <= 1'b0;
      end

      if (s1_fire && s1_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_time_q     <= time_value_i;
      s1_start_q    <= line_start_i;
      s1_fwd_data_q <= wr_entry;
    end
    if (s1_fire && s1_emit) begin
      delta_q  <= s1_delta;
      status_q <= s1_status;
      if (s1_ok) begin
        code_q        <= s1_hit ? entry.code : code_next;
        new_entry_q   <= !s1_hit;
        frame_start_q <= (frame_q == '0);
        frame_time_q  <= (frame_q == '0) ? prev_q : '0;
      end else begin
        code_q        <= '0;
        new_entry_q   <= 1'b0;
        frame_start_q <= 1'b0;
        frame_time_q  <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_o        = code_q;
  assign new_entry_o   = new_entry_q;
  assign delta_value_o = delta_q;
  assign frame_start_o = frame_start_q;
  assign frame_time_o  = frame_time_q;
  assign status_o      = status_q;

  a_no_accept_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o)
    else $error("request accepted during table sweep");

  a_codes_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    codes_q <= dde_pkg::CODE_W'(dde_pkg::MAX_CODES))
    else $error("code count beyond dictionary size");

  a_new_entry_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && new_entry_q) |-> (status_q == dde_pkg::STAT_OK && code_q != '0 &&
                                      code_q <= dde_pkg::CODE_W'(dde_pkg::MAX_CODES)))
    else $error("fresh code outside the dictionary range");

  a_sweep_empty_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s1_valid_q)
    else $error("read stage busy during table sweep");

  a_fwd_needs_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fwd_q |-> s1_valid_q)
    else $error("forwarded entry without a request in the read stage");

endmodule
